### design/sorted_timer_event_queue_top_defines.svh
// Assertion macros for the list engine of the timer queue.
`ifndef SORTED_TIMER_EVENT_QUEUE_TOP_DEFINES_SVH
`define SORTED_TIMER_EVENT_QUEUE_TOP_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define STQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
// Next-cycle implication checked outside reset.
`define STQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`endif

### design/stq_pkg.sv
// Shared types and constants of the sorted timer event queue.
package stq_pkg;
  localparam int SLOTS_DEF = 16;
  localparam int TICK_BITS_DEF = 64;
  localparam int MAX_BURST = 16;
  localparam int CMDQ_DEPTH = 2;

  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_REG = 3'd1;
  localparam logic [2:0] OP_UNREG = 3'd2;
  localparam logic [2:0] OP_PROC = 3'd3;
  localparam logic [2:0] OP_READ = 3'd4;

  typedef struct packed {
    logic [2:0] operation;
    logic [3:0] event_id;
    logic [15:0] timeout;
    logic periodic;
  } in_item_t;

  typedef struct packed {
    logic fired;
    logic [3:0] fired_id;
    logic status;
    logic [63:0] tick_value;
    logic last;
  } out_item_t;

  // Command classified by the front end.
  typedef enum logic [2:0] {
    CMD_NOP = 3'd0,
    CMD_IMM = 3'd1,
    CMD_REG = 3'd2,
    CMD_UNREG = 3'd3,
    CMD_PROC = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic [3:0] id;
    logic [15:0] timeout;
    logic periodic;
    logic status;
    logic [63:0] tick;
  } cmd_t;
endpackage

### design/stq_front.sv
// Front end: keeps the tick counter and turns input items into commands.
module stq_front import stq_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  parameter int TICK_BITS = TICK_BITS_DEF
) (
  input logic clk,
  input logic rst,
  input in_item_t in_item,
  input logic push,
  output logic full,
  output cmd_t cmd,
  output logic cmd_valid,
  input logic cmd_ready
);
  logic [TICK_BITS-1:0] tick_count;
  logic [TICK_BITS-1:0] tick_inc;
  logic in_range;
  logic accept;

  assign full = !cmd_ready;
  assign cmd_valid = push;
  assign accept = push && cmd_ready;
  assign tick_inc = tick_count + TICK_BITS'(1);
  // Ids at or beyond SLOTS cannot be reached by a 4-bit field when SLOTS >= 16.
  assign in_range = (SLOTS >= 16) ? 1'b1 : (in_item.event_id < 4'(SLOTS));

  always_comb begin
    cmd = '0;
    cmd.kind = CMD_NOP;
    cmd.id = in_item.event_id;
    cmd.timeout = in_item.timeout;
    cmd.periodic = in_item.periodic;
    cmd.tick = 64'(tick_count);
    case (in_item.operation)
      OP_TICK: begin
        cmd.tick = 64'(tick_inc);
      end
      OP_REG: begin
        if (in_range && in_item.timeout == '0) begin
          cmd.kind = CMD_IMM;
          cmd.status = in_item.periodic;
        end else if (in_range) begin
          cmd.kind = CMD_REG;
        end
      end
      OP_UNREG: begin
        if (in_range) cmd.kind = CMD_UNREG;
      end
      OP_PROC: begin
        cmd.kind = CMD_PROC;
      end
      default: begin
        cmd.kind = CMD_NOP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
    end else if (accept && in_item.operation == OP_TICK) begin
      tick_count <= tick_inc;
    end
  end
endmodule

### design/stq_cmdq.sv
// Short command queue between the front end and the list engine.
module stq_cmdq import stq_pkg::*; (
  input logic clk,
  input logic rst,
  input cmd_t wr_data,
  input logic wr_valid,
  output logic wr_ready,
  output cmd_t rd_data,
  output logic rd_valid,
  input logic rd_ready
);
  cmd_t mem [CMDQ_DEPTH];
  logic [$clog2(CMDQ_DEPTH)-1:0] wp, rp;
  logic [$clog2(CMDQ_DEPTH):0] cnt;
  logic do_wr, do_rd;

  assign wr_ready = cnt < ($clog2(CMDQ_DEPTH)+1)'(CMDQ_DEPTH);
  assign rd_valid = cnt != '0;
  assign rd_data = mem[rp];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (do_wr) wp <= wp + 1'b1;
      if (do_rd) rp <= rp + 1'b1;
      cnt <= cnt + ($clog2(CMDQ_DEPTH)+1)'(do_wr) - ($clog2(CMDQ_DEPTH)+1)'(do_rd);
    end
  end
endmodule

### design/stq_engine.sv
// List engine: keeps the ordered event list and produces result items.
module stq_engine import stq_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  parameter int TICK_BITS = TICK_BITS_DEF
) (
  input logic clk,
  input logic rst,
  input cmd_t cmd,
  input logic cmd_valid,
  output logic cmd_ready,
  output out_item_t res,
  output logic empty,
  input logic pop
);
  `include "sorted_timer_event_queue_top_defines.svh"
  localparam int IW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 1);
  localparam int BURST = (SLOTS < MAX_BURST) ? SLOTS : MAX_BURST;
  localparam int BW = $clog2(BURST + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RMSRCH = 7'b0000010,
    S_RMSHFT = 7'b0000100,
    S_INSRCH = 7'b0001000,
    S_INSHFT = 7'b0010000,
    S_EMIT = 7'b0100000,
    S_PHEAD = 7'b1000000
  } state_t;

  state_t state;
  cmd_t cur;
  logic [IW-1:0] order [SLOTS];
  logic [SLOTS-1:0] active;
  logic periodic_s [SLOTS];
  logic [15:0] period_s [SLOTS];
  logic [TICK_BITS-1:0] due_s [SLOTS];
  logic [LW-1:0] len;
  logic [LW-1:0] pos;
  logic [LW-1:0] sh;
  logic [IW-1:0] tgt;
  logic [3:0] pend_id;
  logic [BW-1:0] nfired;
  logic after_proc;
  logic res_valid;
  out_item_t res_r;
  logic [TICK_BITS-1:0] tick_t;
  logic [TICK_BITS-1:0] tgt_due;
  logic [IW-1:0] head;
  logic pos_end;

  assign tick_t = cur.tick[TICK_BITS-1:0];
  assign tgt_due = due_s[tgt];
  assign head = order[0];
  assign pos_end = (pos >= len);
  assign cmd_ready = (state == S_IDLE) && !res_valid;
  assign empty = !res_valid;
  assign res = res_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      active <= '0;
      len <= '0;
      res_valid <= 1'b0;
      nfired <= '0;
      after_proc <= 1'b0;
    end else begin
      if (res_valid && pop) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            cur <= cmd;
            nfired <= '0;
            after_proc <= 1'b0;
            case (cmd.kind)
              CMD_IMM: begin
                res_r <= '{fired: 1'b1, fired_id: cmd.id, status: cmd.status,
                           tick_value: cmd.tick, last: 1'b1};
                res_valid <= 1'b1;
              end
              CMD_REG, CMD_UNREG: begin
                res_r <= '{fired: 1'b0, fired_id: 4'd0, status: 1'b0,
                           tick_value: cmd.tick, last: 1'b0};
                pos <= '0;
                tgt <= IW'(cmd.id);
                state <= S_RMSRCH;
              end
              CMD_PROC: begin
                res_r <= '{fired: 1'b0, fired_id: 4'd0, status: 1'b0,
                           tick_value: cmd.tick, last: 1'b0};
                state <= S_PHEAD;
              end
              default: begin
                res_r <= '{fired: 1'b0, fired_id: 4'd0, status: 1'b0,
                           tick_value: cmd.tick, last: 1'b1};
                res_valid <= 1'b1;
              end
            endcase
          end
        end
        S_RMSRCH: begin
          if (!active[tgt] || pos_end) begin
            active[tgt] <= 1'b0;
            if (after_proc) begin
              // A fired periodic event goes back in one period later.
              if (periodic_s[tgt]) begin
                due_s[tgt] <= tick_t + TICK_BITS'(period_s[tgt]);
                pos <= '0;
                state <= S_INSRCH;
              end else begin
                state <= S_PHEAD;
              end
            end else if (cur.kind == CMD_REG) begin
              periodic_s[tgt] <= cur.periodic;
              period_s[tgt] <= cur.timeout;
              due_s[tgt] <= tick_t + TICK_BITS'(cur.timeout);
              pos <= '0;
              state <= S_INSRCH;
            end else begin
              res_r.last <= 1'b1;
              res_valid <= 1'b1;
              state <= S_IDLE;
            end
          end else if (order[pos[IW-1:0]] == tgt) begin
            state <= S_RMSHFT;
          end else begin
            pos <= pos + 1'b1;
          end
        end
        S_RMSHFT: begin
          if (pos + 1'b1 >= len) begin
            len <= len - 1'b1;
            active[tgt] <= 1'b0;
            state <= S_RMSRCH;
            pos <= len;
          end else begin
            order[pos[IW-1:0]] <= order[pos[IW-1:0] + 1'b1];
            pos <= pos + 1'b1;
          end
        end
        S_INSRCH: begin
          if (len >= LW'(SLOTS)) begin
            state <= S_EMIT;
          end else if (!pos_end && due_s[order[pos[IW-1:0]]] < tgt_due) begin
            pos <= pos + 1'b1;
          end else begin
            sh <= len;
            state <= S_INSHFT;
          end
        end
        S_INSHFT: begin
          // Shift from the tail down to the insert point, one entry a cycle.
          if (sh == pos) begin
            order[pos[IW-1:0]] <= tgt;
            len <= len + 1'b1;
            active[tgt] <= 1'b1;
            state <= S_EMIT;
          end else begin
            order[sh[IW-1:0]] <= order[sh[IW-1:0] - 1'b1];
            sh <= sh - 1'b1;
          end
        end
        S_EMIT: begin
          if (after_proc) begin
            state <= S_PHEAD;
          end else if (!res_valid) begin
            res_r.last <= 1'b1;
            res_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_PHEAD: begin
          if (!res_valid) begin
            if (nfired < BW'(BURST) && len != '0 && due_s[head] <= tick_t) begin
              // Another event fires, so the one held back is not the last.
              if (nfired != '0) begin
                res_r <= '{fired: 1'b1, fired_id: pend_id, status: 1'b0,
                           tick_value: cur.tick, last: 1'b0};
                res_valid <= 1'b1;
              end
              pend_id <= 4'(head);
              nfired <= nfired + 1'b1;
              tgt <= head;
              pos <= '0;
              after_proc <= 1'b1;
              state <= S_RMSRCH;
            end else begin
              if (nfired != '0) begin
                res_r <= '{fired: 1'b1, fired_id: pend_id, status: 1'b0,
                           tick_value: cur.tick, last: 1'b1};
              end else begin
                res_r.last <= 1'b1;
              end
              res_valid <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `STQ_ASSERT_IMP(a_len_bound, 1'b1, len <= LW'(SLOTS))
  `STQ_ASSERT_IMP(a_ready_idle, cmd_ready, state == S_IDLE)
  `STQ_ASSERT_NXT(a_pop_clears, res_valid && pop && state == S_IDLE && !cmd_valid, !res_valid)
endmodule

### design/sorted_timer_event_queue_top.sv
// Top level of the sorted timer event queue.
//
// Input channel: push/full with an in_item struct; an item is taken when push
// is high and full is low. Result channel: empty/pop with a res struct; the
// oldest result is shown while empty is low and is taken when pop is high.
// Every operation gives one result, except process due, which gives one per
// fired event (at most 16), or one with fired low if none is due. The last
// result of an item carries last high.
// An item that is taken waits in the command queue until the list engine
// takes it; a tick, read or immediate fire has its result registered then.
// Register and unregister walk the ordered list one entry a cycle, and
// process due repeats such walks for each fired event. Items are handled
// one at a time: the engine takes the next one only after its previous
// result has been popped.
// Reset clears the tick counter and empties the list at once.
// When the receiver stalls, the list engine holds its result and stops; the
// command queue then fills and full rises.
module sorted_timer_event_queue_top import stq_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  parameter int TICK_BITS = TICK_BITS_DEF
) (
  input logic clk,
  input logic rst,
  input in_item_t in_item,
  input logic push,
  output logic full,
  output out_item_t res,
  output logic empty,
  input logic pop
);
  cmd_t f_cmd, q_cmd;
  logic f_valid, f_ready, q_valid, q_ready;

  stq_front #(.SLOTS(SLOTS), .TICK_BITS(TICK_BITS)) u_front (
    .clk, .rst, .in_item, .push, .full,
    .cmd(f_cmd), .cmd_valid(f_valid), .cmd_ready(f_ready)
  );

  stq_cmdq u_q (
    .clk, .rst, .wr_data(f_cmd), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_data(q_cmd), .rd_valid(q_valid), .rd_ready(q_ready)
  );

  stq_engine #(.SLOTS(SLOTS), .TICK_BITS(TICK_BITS)) u_eng (
    .clk, .rst, .cmd(q_cmd), .cmd_valid(q_valid), .cmd_ready(q_ready),
    .res, .empty, .pop
  );
endmodule

### sim/tb.sv
// Self-checking testbench for the sorted timer event queue.
`timescale 1ns / 1ps
module tb;
  import stq_pkg::*;

  localparam int NSLOT = 16;
  localparam int BURST_MAX = 16;
  localparam int DRAIN_CYCLES = 1000;
  localparam logic [2:0] OP_BAD5 = 3'd5;
  localparam logic [2:0] OP_BAD6 = 3'd6;
  localparam logic [2:0] OP_BAD7 = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  in_item_t in_item = '0;
  logic push = 1'b0;
  logic full;
  out_item_t res;
  logic empty;
  logic pop = 1'b0;

  sorted_timer_event_queue_top uut (
    .clk(clk), .rst(rst), .in_item(in_item), .push(push), .full(full),
    .res(res), .empty(empty), .pop(pop)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the timer state.
  logic [63:0] ticks = '0;
  logic armed [NSLOT];
  logic rearm [NSLOT];
  logic [15:0] period [NSLOT];
  logic [63:0] due [NSLOT];
  int order [$];

  out_item_t fired_events [$];
  int fails = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_results = 1'b0;

  initial for (int i = 0; i < NSLOT; i++) armed[i] = 1'b0;

  function automatic void add_result(logic f, logic [3:0] id, logic st);
    out_item_t r;
    r.fired = f;
    r.fired_id = id;
    r.status = st;
    r.tick_value = ticks;
    r.last = 1'b0;
    fired_events.push_back(r);
  endfunction

  function automatic void unlink(int id);
    for (int i = 0; i < order.size(); i++) begin
      if (order[i] == id) begin
        order.delete(i);
        break;
      end
    end
    armed[id] = 1'b0;
  endfunction

  // New entries go ahead of entries with an equal due time.
  function automatic void link(int id);
    int pos;
    pos = 0;
    if (order.size() >= NSLOT) return;
    while (pos < order.size() && due[order[pos]] < due[id]) pos++;
    order.insert(pos, id);
    armed[id] = 1'b1;
  endfunction

  function automatic void predict_timer(in_item_t it);
    int n;
    int h;
    n = 0;
    case (it.operation)
      OP_TICK: begin
        ticks = ticks + 64'd1;
        add_result(1'b0, 4'd0, 1'b0);
      end
      OP_REG: begin
        if (it.timeout == 16'd0) begin
          add_result(1'b1, it.event_id, it.periodic);
        end else begin
          if (armed[it.event_id]) unlink(it.event_id);
          rearm[it.event_id] = it.periodic;
          period[it.event_id] = it.timeout;
          due[it.event_id] = ticks + 64'(it.timeout);
          link(it.event_id);
          add_result(1'b0, 4'd0, 1'b0);
        end
      end
      OP_UNREG: begin
        if (armed[it.event_id]) unlink(it.event_id);
        add_result(1'b0, 4'd0, 1'b0);
      end
      OP_PROC: begin
        while (n < BURST_MAX && order.size() > 0 && due[order[0]] <= ticks) begin
          h = order[0];
          unlink(h);
          add_result(1'b1, 4'(h), 1'b0);
          n++;
          if (rearm[h]) begin
            due[h] = ticks + 64'(period[h]);
            link(h);
          end
        end
        if (n == 0) add_result(1'b0, 4'd0, 1'b0);
      end
      default: add_result(1'b0, 4'd0, 1'b0);
    endcase
    fired_events[$].last = 1'b1;
  endfunction

  // Called at a falling edge; returns at a falling edge with push still high.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    in_item <= it;
    push <= 1'b1;
    do @(posedge clk); while (full);
    predict_timer(it);
    @(negedge clk);
  endtask

  task automatic send_op(logic [2:0] op, int id, int tmo, bit per);
    in_item_t it;
    it.operation = op;
    it.event_id = 4'(id);
    it.timeout = 16'(tmo);
    it.periodic = per;
    send_item(it);
  endtask

  task automatic send_ticks(int count);
    for (int i = 0; i < count; i++)
      send_op(OP_TICK, $urandom_range(15), $urandom, 1'($urandom));
  endtask

  always @(negedge clk) begin
    if (rst || hold_results) pop <= 1'b0;
    else pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (fired_events.size() == 0) begin
        $display("%0t: unexpected transaction, actual %p", $realtime, res);
        fails++;
      end else begin
        out_item_t e;
        e = fired_events.pop_front();
        if (res.fired !== e.fired || res.fired_id !== e.fired_id ||
            res.status !== e.status || res.tick_value !== e.tick_value ||
            res.last !== e.last) begin
          $display("%0t: mismatch, expected %p, actual %p", $realtime, e, res);
          fails++;
        end
      end
    end
  end

  task automatic test_simple_ops();
    send_op(OP_READ, 0, 0, 1'b0);
    send_op(OP_TICK, 15, 16'hFFFF, 1'b1);
    send_op(OP_READ, 15, 16'hFFFF, 1'b1);
    send_op(OP_BAD5, 3, 7, 1'b0);
    send_op(OP_BAD6, 0, 0, 1'b1);
    send_op(OP_BAD7, 15, 16'hFFFF, 1'b1);
    send_op(OP_UNREG, 9, 0, 1'b0);
    send_op(OP_PROC, 0, 0, 1'b0);
  endtask

  task automatic test_immediate_fire();
    send_op(OP_REG, 4, 0, 1'b0);
    send_op(OP_REG, 15, 0, 1'b1);
    // A zero timeout leaves an armed slot untouched.
    send_op(OP_REG, 2, 3, 1'b0);
    send_op(OP_REG, 2, 0, 1'b1);
    send_op(OP_REG, 0, 16'hFFFF, 1'b1);
  endtask

  task automatic test_ordering();
    send_op(OP_REG, 5, 2, 1'b0);
    send_op(OP_REG, 6, 2, 1'b0);
    send_op(OP_REG, 7, 1, 1'b1);
    send_op(OP_REG, 5, 4, 1'b0);
    send_op(OP_UNREG, 0, 0, 1'b0);
    send_ticks(3);
    send_op(OP_PROC, 0, 0, 1'b0);
    send_op(OP_PROC, 0, 0, 1'b0);
  endtask

  // Sixteen events due at once fill one whole burst; the periodic one re-arms.
  task automatic test_full_burst();
    for (int i = 0; i < NSLOT; i++) send_op(OP_REG, i, 1, i == 3);
    send_ticks(2);
    send_op(OP_PROC, 0, 0, 1'b0);
    send_op(OP_PROC, 0, 0, 1'b0);
    for (int i = 0; i < NSLOT; i++) send_op(OP_UNREG, i, 0, 1'b0);
  endtask

  task automatic test_receiver_stall();
    push <= 1'b0;
    @(posedge clk);
    hold_results = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_results = 1'b0;
      end
    join_none
    @(negedge clk);
    for (int i = 0; i < 24; i++) send_op(i % 3 == 0 ? OP_READ : OP_TICK, i, i, 1'b0);
  endtask

  task automatic test_random(int count);
    int pick;
    int tmo;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      case ($urandom_range(9))
        0: tmo = 0;
        1: tmo = $urandom_range(65535);
        default: tmo = $urandom_range(1, 12);
      endcase
      if (pick < 35)
        send_op(OP_TICK, $urandom_range(15), $urandom, 1'($urandom));
      else if (pick < 60)
        send_op(OP_REG, $urandom_range(15), tmo, 1'($urandom));
      else if (pick < 70)
        send_op(OP_UNREG, $urandom_range(15), $urandom, 1'($urandom));
      else if (pick < 90)
        send_op(OP_PROC, $urandom_range(15), $urandom, 1'($urandom));
      else if (pick < 95)
        send_op(OP_READ, $urandom_range(15), $urandom, 1'($urandom));
      else
        send_op(3'($urandom_range(5, 7)), $urandom_range(15), $urandom, 1'($urandom));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_idle_pct = 22;
    recv_idle_pct = 56;
    test_simple_ops();
    test_immediate_fire();
    test_ordering();
    test_full_burst();
    test_random(60);
    send_idle_pct = 56;
    recv_idle_pct = 22;
    test_receiver_stall();
    test_random(60);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(60);
    push <= 1'b0;
    wait (fired_events.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
